// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property on every rising clock edge, disabled while in reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`endif

// ----- rtl/smpd_pkg.sv -----
// shared types and constants of the move planner
// no dependencies
package smpd_pkg;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam logic [30:0] StepMax = 31'h7fffffff;

  typedef enum logic [2:0] {
    CfgSpuX = 3'd0, CfgSpuY = 3'd1, CfgSpuZ = 3'd2, CfgMinRate = 3'd3,
    CfgMaxRate = 3'd4, CfgMinSpin = 3'd5, CfgMaxSpin = 3'd6, CfgShortLim = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StQueued = 2'd0, StDropped = 2'd1, StFull = 2'd2, StDispatched = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    McNone = 3'd0, McToolOn = 3'd1, McToolOff = 3'd2, McOther = 3'd3,
    McComment = 3'd4, McEnd = 3'd5, McSpare6 = 3'd6, McSpare7 = 3'd7
  } mcode_e;

  typedef enum logic [2:0] {
    FsmIdle, FsmMul, FsmDelta, FsmDecide, FsmRead, FsmDisp, FsmOut
  } fsm_e;

  // one queued block minus its step counts
  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] spin;
    logic [2:0]  kind;
    logic [2:0]  dir;
  } info_t;
endpackage

// ----- rtl/smpd_scale.sv -----
// per-axis scaling of a Q16.16 target by Q16.8 steps per unit, rounded
// depends on smpd_pkg; multiply with a registered product
module smpd_scale (
  input  logic        clk_i,
  input  logic        start_i,
  input  logic [31:0] target_i,
  input  logic [23:0] spu_i,
  output logic signed [40:0] tgt_o
);
  import smpd_pkg::*;
  logic        neg_q;
  logic [55:0] prod_q;
  logic [31:0] mag;
  logic [32:0] q;

  // magnitude of the target
  assign mag = target_i[31] ? (32'd0 - target_i) : target_i;

  // registered product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= mag * spu_i;
      neg_q  <= target_i[31];
    end
  end

  // round half away from zero
  assign q = 33'((prod_q + 56'h800000) >> 24);
  assign tgt_o = neg_q ? (41'sd0 - $signed({8'd0, q})) : $signed({8'd0, q});
endmodule

// ----- rtl/stepper_move_planner_dispatch_top.sv -----
// top level of the three-axis move planner with its block queue
// depends on smpd_pkg, smpd_scale and assert_macros.svh
//
// One request is worked on at a time. A plan request goes through capture
// and multiply, delta, queue decision and result, in that order. A dispatch
// tick goes through the registered read of the block memories, dispatch
// and result. A comment or end code goes from capture and multiply straight
// to the result. A tick on an empty queue ends after the read with no
// result. The output register parts the two sides: a result that is not
// yet taken holds the next one in its last stage, and the input stays off
// until the output register frees up. The block memories need no clearing
// pass.
`include "assert_macros.svh"
module stepper_move_planner_dispatch_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [smpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smpd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: target_x, target_y, target_z, mcode_kind, spindle_request, rate_request
  input  logic [135:0] s_axis_tdata,
  // tuser: req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: pos_x, pos_y, pos_z, steps_x, steps_y, steps_z, dir_bits,
  // step_rate, spindle_valid, spindle_speed, autorun_start
  output logic [231:0] m_axis_tdata,
  // tuser: status
  output logic [1:0]   m_axis_tuser
);
  import smpd_pkg::*;
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [23:0] spu_q [3];
  logic [15:0] min_rate_q, max_rate_q, min_spin_q, max_spin_q, short_lim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spu_q[0] <= 24'd204800; spu_q[1] <= 24'd204800; spu_q[2] <= 24'd42327;
      min_rate_q <= 16'd180; max_rate_q <= 16'd1000; min_spin_q <= 16'd0;
      max_spin_q <= 16'd2000; short_lim_q <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSpuX:     spu_q[0] <= cfg_data_i;
        CfgSpuY:     spu_q[1] <= cfg_data_i;
        CfgSpuZ:     spu_q[2] <= cfg_data_i;
        CfgMinRate:  min_rate_q <= cfg_data_i[15:0];
        CfgMaxRate:  max_rate_q <= cfg_data_i[15:0];
        CfgMinSpin:  min_spin_q <= cfg_data_i[15:0];
        CfgMaxSpin:  max_spin_q <= cfg_data_i[15:0];
        CfgShortLim: short_lim_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // request capture
  fsm_e state_q, state_d;
  logic [135:0] req_q;
  logic         type_q;
  logic         in_acc;
  assign s_axis_tready = (state_q == FsmIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= s_axis_tdata;
      type_q <= s_axis_tuser;
    end
  end
  logic [2:0]  kind;
  logic [15:0] spin_r, rate_r;
  assign kind   = req_q[98:96];
  assign spin_r = req_q[114:99];
  assign rate_r = req_q[130:115];

  // axis position and queue pointers
  logic [31:0]     pos_q [3];
  logic [PtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q;

  // registered read data of the block memories
  logic [30:0] step_rd_q [3];
  info_t       info_rd_q;

  // scalers, one per axis
  logic signed [40:0] tgt [3];
  logic [30:0] steps_q [3];
  logic [2:0]  dir_q;
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [41:0] delta;
    logic [41:0]        dmag;
    smpd_scale u_scale (
      .clk_i   (clk_i),
      .start_i (state_q == FsmMul),
      .target_i(req_q[32*a +: 32]),
      .spu_i   (spu_q[a]),
      .tgt_o   (tgt[a])
    );
    assign delta = 42'(tgt[a]) - 42'($signed(pos_q[a]));
    assign dmag  = delta[41] ? (42'd0 - delta) : delta;
    always_ff @(posedge clk_i) begin
      if (state_q == FsmDelta) begin
        steps_q[a] <= (dmag > 42'(StepMax)) ? StepMax : dmag[30:0];
        dir_q[a]   <= delta[41];
      end else if (state_q == FsmDisp) begin
        steps_q[a] <= step_rd_q[a];
      end
    end
  end

  // block memories, registered read
  logic [92:0] step_mem [QUEUE_DEPTH];
  info_t       info_mem [QUEUE_DEPTH];
  logic        mem_we;
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      step_mem[tail_q] <= {steps_q[2], steps_q[1], steps_q[0]};
      info_mem[tail_q] <= '{rate: rate_r, spin: spin_r, kind: kind, dir: dir_q};
    end
    if (state_q == FsmRead) begin
      step_rd_q[0] <= step_mem[head_q][30:0];
      step_rd_q[1] <= step_mem[head_q][61:31];
      step_rd_q[2] <= step_mem[head_q][92:62];
      info_rd_q    <= info_mem[head_q];
    end
  end

  // plan decision
  logic drop_cmt, zero_move, is_full;
  assign drop_cmt  = (kind == McComment) || (kind == McEnd);
  assign zero_move = (steps_q[0] == '0) && (steps_q[1] == '0) &&
                     (steps_q[2] == '0) && (kind == McNone);
  assign is_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign mem_we    = (state_q == FsmDecide) && !zero_move && !is_full;

  // next state
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle:   if (in_acc) state_d = s_axis_tuser ? FsmRead : FsmMul;
      FsmMul:    state_d = drop_cmt ? FsmOut : FsmDelta;
      FsmDelta:  state_d = FsmDecide;
      FsmDecide: state_d = FsmOut;
      FsmRead:   state_d = (count_q == '0) ? FsmIdle : FsmDisp;
      FsmDisp:   state_d = FsmOut;
      FsmOut:    if (out_free) state_d = FsmIdle;
      default:   state_d = FsmIdle;
    endcase
  end

  // dispatch values from the read block
  logic [30:0] longest;
  logic [15:0] rate_sel, spin_sel;
  logic        spin_vld;
  always_comb begin
    longest = step_rd_q[0];
    if (step_rd_q[1] > longest) longest = step_rd_q[1];
    if (step_rd_q[2] > longest) longest = step_rd_q[2];
    if (longest < 31'(short_lim_q)) rate_sel = min_rate_q;
    else rate_sel = (info_rd_q.rate > max_rate_q) ? max_rate_q : info_rd_q.rate;
    spin_vld = 1'b0;
    spin_sel = '0;
    if (info_rd_q.kind == McToolOn) begin
      spin_vld = 1'b1;
      spin_sel = (info_rd_q.spin > max_spin_q) ? max_spin_q : info_rd_q.spin;
    end else if (info_rd_q.kind == McToolOff) begin
      spin_vld = 1'b1;
      spin_sel = min_spin_q;
    end
  end

  // state, queue, position and result registers
  logic [31:0] npos [3];
  always_comb begin
    for (int a = 0; a < 3; a++)
      npos[a] = info_rd_q.dir[a] ? pos_q[a] - {1'b0, step_rd_q[a]}
                                 : pos_q[a] + {1'b0, step_rd_q[a]};
  end
  logic [1:0]  status_q;
  logic [15:0] o_rate_q, o_spin_q;
  logic        o_spv_q, o_auto_q, o_dispatch_q;
  logic [2:0]  o_dir_q;
  logic [31:0] o_pos_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      head_q <= '0; tail_q <= '0; count_q <= '0;
      pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state_q == FsmOut && out_free) m_axis_tvalid <= 1'b1;
      if (mem_we) begin
        tail_q  <= (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (state_q == FsmDisp) begin
        head_q  <= (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
        for (int a = 0; a < 3; a++) pos_q[a] <= npos[a];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == FsmMul) begin
      status_q <= StDropped;
      o_dispatch_q <= 1'b0;
      for (int a = 0; a < 3; a++) o_pos_q[a] <= pos_q[a];
    end
    if (state_q == FsmDecide)
      status_q <= zero_move ? StDropped : (is_full ? StFull : StQueued);
    if (state_q == FsmDisp) begin
      status_q <= StDispatched;
      o_dispatch_q <= 1'b1;
      for (int a = 0; a < 3; a++) o_pos_q[a] <= npos[a];
      o_dir_q  <= info_rd_q.dir;
      o_rate_q <= rate_sel;
      o_spv_q  <= spin_vld;
      o_spin_q <= spin_sel;
      o_auto_q <= (info_rd_q.kind == McNone);
    end
  end

  // result packing, plan results carry zero dispatch fields
  logic d;
  logic [231:0] res_data;
  assign d = o_dispatch_q;
  assign res_data = {6'b0, d & o_auto_q, d ? o_spin_q : 16'd0, d & o_spv_q,
                     d ? o_rate_q : 16'd0, d ? o_dir_q : 3'd0,
                     d ? steps_q[2] : 31'd0, d ? steps_q[1] : 31'd0,
                     d ? steps_q[0] : 31'd0, o_pos_q[2], o_pos_q[1], o_pos_q[0]};

  // output register, loaded when the result slot frees up
  always_ff @(posedge clk_i) begin
    if (state_q == FsmOut && out_free) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= status_q;
    end
  end

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CntW'(QUEUE_DEPTH), "count overflow")
  `ASSERT_CLK(a_no_write_full, clk_i, rst_ni, !(mem_we && is_full), "write to full queue")
  `ASSERT_CLK(a_ready_idle, clk_i, rst_ni, !(s_axis_tready && state_q != FsmIdle), "ready busy")
endmodule

// ----- sim/smpd_result_checker.sv -----
// result checker for the move planner: watches config writes, requests and results
// depends on smpd_pkg for the register, status and m-code codes, the block type and the step limit
`timescale 1ns / 100ps
module smpd_result_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [231:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);
  import smpd_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [30:0] steps_x, steps_y, steps_z;
    logic [2:0]  dir;
    logic [15:0] rate;
    logic        spin_valid;
    logic [15:0] spin_speed;
    logic        autorun;
  } move_result_t;

  // planner state mirror
  logic [23:0] spu [3];
  logic [15:0] min_rate, max_rate, min_spin, max_spin, short_lim;
  logic [31:0] position [3];
  logic [30:0] blk_steps [Depth][3];
  info_t       blk_info [Depth];
  int unsigned head, tail, count;
  move_result_t result_q [$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  // round(target * spu), ties away from zero
  function automatic longint scaled_target(logic [31:0] t, logic [23:0] s);
    logic [63:0] mag, q;
    mag = t[31] ? {32'd0, -t} : {32'd0, t};
    q = (mag * {40'd0, s} + 64'd8388608) >> 24;
    return t[31] ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_request(logic req, logic [135:0] d);
    move_result_t r;
    logic [31:0] tgt [3];
    logic [2:0]  kind, dir;
    logic [15:0] spin, rate;
    logic [30:0] st [3];
    logic [30:0] longest;
    longint delta;
    longint mag;
    info_t inf;
    tgt[0] = d[31:0];
    tgt[1] = d[63:32];
    tgt[2] = d[95:64];
    kind = d[98:96];
    spin = d[114:99];
    rate = d[130:115];
    r = '0;
    dir = '0;
    longest = '0;
    if (!req) begin
      r.pos_x = position[0];
      r.pos_y = position[1];
      r.pos_z = position[2];
      if (kind == McComment || kind == McEnd) begin
        r.status = StDropped;
      end else begin
        for (int a = 0; a < 3; a++) begin
          delta = scaled_target(tgt[a], spu[a]) - longint'($signed(position[a]));
          mag = (delta < 0) ? -delta : delta;
          st[a] = (mag > 64'h7fffffff) ? StepMax : mag[30:0];
          if (delta < 0) dir[a] = 1'b1;
          if (st[a] > longest) longest = st[a];
        end
        if (longest == 0 && kind == McNone) begin
          r.status = StDropped;
        end else if (count >= Depth) begin
          r.status = StFull;
        end else begin
          for (int a = 0; a < 3; a++) blk_steps[tail][a] = st[a];
          inf.rate = rate;
          inf.spin = spin;
          inf.kind = kind;
          inf.dir = dir;
          blk_info[tail] = inf;
          tail = (tail + 1) % Depth;
          count++;
          r.status = StQueued;
        end
      end
      result_q.push_back(r);
    end else if (count != 0) begin
      // dispatch the oldest block
      inf = blk_info[head];
      for (int a = 0; a < 3; a++) begin
        st[a] = blk_steps[head][a];
        if (st[a] > longest) longest = st[a];
        position[a] = inf.dir[a] ? position[a] - {1'b0, st[a]} : position[a] + {1'b0, st[a]};
      end
      head = (head + 1) % Depth;
      count--;
      r.status = StDispatched;
      r.pos_x = position[0];
      r.pos_y = position[1];
      r.pos_z = position[2];
      r.steps_x = st[0];
      r.steps_y = st[1];
      r.steps_z = st[2];
      r.dir = inf.dir;
      if ({1'b0, longest} < {16'd0, short_lim}) r.rate = min_rate;
      else r.rate = (inf.rate > max_rate) ? max_rate : inf.rate;
      if (inf.kind == McToolOn) begin
        r.spin_valid = 1'b1;
        r.spin_speed = (inf.spin > max_spin) ? max_spin : inf.spin;
      end else if (inf.kind == McToolOff) begin
        r.spin_valid = 1'b1;
        r.spin_speed = min_spin;
      end
      r.autorun = (inf.kind == McNone);
      result_q.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result(logic [231:0] d, logic [1:0] st);
    move_result_t e;
    if (result_q.size() == 0) begin
      $error("result with nothing outstanding: status %0d", st);
      errors++;
      return;
    end
    e = result_q.pop_front();
    check_field("status", 32'(e.status), 32'(st));
    check_field("pos_x", e.pos_x, d[31:0]);
    check_field("pos_y", e.pos_y, d[63:32]);
    check_field("pos_z", e.pos_z, d[95:64]);
    check_field("steps_x", 32'(e.steps_x), 32'(d[126:96]));
    check_field("steps_y", 32'(e.steps_y), 32'(d[157:127]));
    check_field("steps_z", 32'(e.steps_z), 32'(d[188:158]));
    check_field("dir_bits", 32'(e.dir), 32'(d[191:189]));
    check_field("step_rate", 32'(e.rate), 32'(d[207:192]));
    check_field("spindle_valid", 32'(e.spin_valid), 32'(d[208]));
    check_field("spindle_speed", 32'(e.spin_speed), 32'(d[224:209]));
    check_field("autorun_start", 32'(e.autorun), 32'(d[225]));
  endtask

  // sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spu[0] = 24'd204800;
      spu[1] = 24'd204800;
      spu[2] = 24'd42327;
      min_rate = 16'd180;
      max_rate = 16'd1000;
      min_spin = 16'd0;
      max_spin = 16'd2000;
      short_lim = 16'd200;
      for (int a = 0; a < 3; a++) position[a] = '0;
      head = 0;
      tail = 0;
      count = 0;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgSpuX:     spu[0] = cfg_data_i;
          CfgSpuY:     spu[1] = cfg_data_i;
          CfgSpuZ:     spu[2] = cfg_data_i;
          CfgMinRate:  min_rate = cfg_data_i[15:0];
          CfgMaxRate:  max_rate = cfg_data_i[15:0];
          CfgMinSpin:  min_spin = cfg_data_i[15:0];
          CfgMaxSpin:  max_spin = cfg_data_i[15:0];
          CfgShortLim: short_lim = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
    end
  end
endmodule

// ----- sim/stepper_move_planner_dispatch_top_tb.sv -----
// testbench top of the move planner: stimulus, config phases and verdict
// depends on smpd_pkg, the planner rtl and smpd_result_checker
`timescale 1ns / 100ps
module stepper_move_planner_dispatch_top_tb;
  import smpd_pkg::*;

  localparam int unsigned ReqPlan = 0;
  localparam int unsigned ReqTick = 1;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [23:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [231:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int errors, pending;
  int send_idle_pct, recv_stall_pct;
  int hold_seq, hold_seen;

  stepper_move_planner_dispatch_top i_dut (.*);

  smpd_result_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #8000000;
    $display("stepper_move_planner_dispatch_top_tb NOT OK");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      m_axis_tready <= 1'b0;
      repeat (400) @(posedge clk_i);
      hold_seen = hold_seq;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_request(int unsigned req, logic [31:0] tx, logic [31:0] ty,
                              logic [31:0] tz, logic [2:0] kind, logic [15:0] spin,
                              logic [15:0] rate);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req[0];
    s_axis_tdata <= {5'd0, rate, spin, kind, tz, ty, tx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // let the pipeline drain, then leave the input idle
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'd0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 655360)) - 32'sd327680;
    endcase
  endfunction

  task automatic rand_plan();
    send_request(ReqPlan, rand_target(), rand_target(), rand_target(),
                 ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : McNone,
                 16'($urandom()), 16'($urandom()));
  endtask

  task automatic rand_tick();
    send_request(ReqTick, $urandom(), $urandom(), $urandom(), 3'($urandom()),
                 16'($urandom()), 16'($urandom()));
  endtask

  // mostly single random plans or ticks, with bursts of plans that can overflow the queue
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat (18) rand_plan();
        repeat (18) rand_tick();
        i += 35;
      end else if ($urandom_range(0, 1)) begin
        rand_plan();
      end else begin
        rand_tick();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSpuX;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    hold_seq = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, drops, extreme targets, every m-code
    send_request(ReqTick, '0, '0, '0, McNone, '0, '0);
    send_request(ReqPlan, '0, '0, '0, McNone, 16'hffff, 16'hffff);
    send_request(ReqPlan, 32'h7fffffff, '0, '0, McComment, '0, '0);
    send_request(ReqPlan, 32'h80000000, '0, '0, McEnd, '0, '0);
    send_request(ReqPlan, 32'h7fffffff, 32'h80000000, 32'hffffffff, McToolOn, 16'hffff, 16'hffff);
    send_request(ReqPlan, 32'h80000000, 32'h7fffffff, 32'h00010000, McToolOff, 16'd5, 16'd0);
    send_request(ReqPlan, 32'h00008000, 32'hffff8000, '0, McOther, 16'd100, 16'd500);
    send_request(ReqPlan, '0, '0, '0, McSpare6, 16'd1, 16'd1);
    send_request(ReqPlan, 32'h00000001, '0, '0, McSpare7, 16'd0, 16'hffff);
    send_request(ReqPlan, 32'h00050000, 32'hfffb0000, 32'h00020000, McNone, 16'd7, 16'd900);
    send_request(ReqPlan, 32'h00050000, 32'hfffb0000, 32'h00020000, McToolOn, 16'd10, 16'd10);
    repeat (8) send_request(ReqTick, '0, '0, '0, McNone, '0, '0);
    drain_requests();

    for (int ph = 0; ph < 5; ph++) begin
      // register setting for this phase
      case (ph)
        1: begin
          write_reg(CfgSpuX, 24'hffffff); write_reg(CfgSpuY, 24'hffffff);
          write_reg(CfgSpuZ, 24'hffffff); write_reg(CfgMinRate, 24'h00ffff);
          write_reg(CfgMaxRate, 24'h00ffff); write_reg(CfgMinSpin, 24'h00ffff);
          write_reg(CfgMaxSpin, 24'h00ffff); write_reg(CfgShortLim, 24'h00ffff);
        end
        2: begin
          write_reg(CfgSpuX, 24'd0); write_reg(CfgSpuY, 24'd1);
          write_reg(CfgSpuZ, 24'd256); write_reg(CfgMinRate, 24'd0);
          write_reg(CfgMaxRate, 24'd0); write_reg(CfgMinSpin, 24'd0);
          write_reg(CfgMaxSpin, 24'd0); write_reg(CfgShortLim, 24'd0);
        end
        3, 4: begin
          write_reg(CfgSpuX, 24'($urandom())); write_reg(CfgSpuY, 24'($urandom_range(0, 300000)));
          write_reg(CfgSpuZ, 24'($urandom_range(0, 300000)));
          write_reg(CfgMinRate, 24'($urandom_range(0, 65535)));
          write_reg(CfgMaxRate, 24'($urandom_range(0, 65535)));
          write_reg(CfgMinSpin, 24'($urandom_range(0, 65535)));
          write_reg(CfgMaxSpin, 24'($urandom_range(0, 65535)));
          write_reg(CfgShortLim, 24'($urandom_range(0, 8000)));
        end
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      random_phase(160);
      // long receiver hold-off while requests keep coming
      hold_seq++;
      random_phase(40);
      // sender pauses until every result is back
      drain_requests();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(120);
      drain_requests();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("stepper_move_planner_dispatch_top_tb OK");
    end else begin
      $display("stepper_move_planner_dispatch_top_tb NOT OK");
    end
    $finish;
  end
endmodule
